>>> design/brar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brar_pkg: shared types and constants for the beacon route table block
// widths, codes, reset values and the controller/datapath command structs
// ----------------------------------------------------------------------------
package brar_pkg;

	localparam int unsigned ROUTE_ENTRIES = 16;
	localparam int unsigned IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ROUTE_ENTRIES + 1);

	localparam logic [31:0] RATE_MAX         = 32'hFFFF_FFFF;
	localparam logic [31:0] RESET_PREV_DELAY = 32'd100000000;
	localparam logic [35:0] ONE_SECOND_Q16   = 36'd65536000000;

	localparam logic [31:0] RESET_EXPIRE    = 32'd10000000;
	localparam logic [24:0] RESET_RATE_STEP = 25'd32768;

	typedef enum logic [1:0] {
		ACT_BEACON = 2'd0,
		ACT_LOOKUP = 2'd1,
		ACT_PURGE  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_OWN_ADDRESS = 2'd0,
		CFG_EXPIRE_TIME = 2'd1,
		CFG_RATE_STEP   = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_OWN_DROP  = 3'd0,
		ST_NEW_FWD   = 3'd1,
		ST_UPD_FWD   = 3'd2,
		ST_REPLACED  = 3'd3,
		ST_IGNORED   = 3'd4,
		ST_FULL      = 3'd5,
		ST_FOUND     = 3'd6,
		ST_NO_ROUTE  = 3'd7
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture the input transaction
		logic scan_clr;    // restart the table scan
		logic scan_step;   // check one entry, advance
		logic rate_pre;    // AIMD update before classification
		logic div_start;   // start the rate divider
		logic div_step;    // one divider iteration
		logic commit;      // write entry / rate, form result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic div_last;
		logic need_div;    // the result needs 1/delay
	} dp_stat_t;

endpackage

>>> design/brar_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brar_ctrl: sequencing controller
// walks load, scan, optional divide and result hand-off for one transaction
// ----------------------------------------------------------------------------
module brar_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output brar_pkg::dp_cmd_t  cmd,
	input  brar_pkg::dp_stat_t stat
);
	import brar_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_DIV  = 5'b00100,
		S_DONE = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					cmd.rate_pre = 1'b1;
					state_d      = S_DIV;
					cmd.div_start = 1'b1;
				end
			end
			S_DIV: begin
				if (stat.need_div && !stat.div_last) begin
					cmd.div_step = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised without commit");
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("ready while result pending");

endmodule

>>> design/brar_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brar_dp: route table, serial scan, AIMD rate and restoring divider
// ----------------------------------------------------------------------------
module brar_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  brar_pkg::dp_cmd_t  cmd,
	output brar_pkg::dp_stat_t stat,
	input  logic [7:0]         own_address,
	input  logic [31:0]        route_expire_time,
	input  logic [24:0]        rate_step,
	input  logic [1:0]         action,
	input  logic [31:0]        now,
	input  logic [7:0]         beacon_source,
	input  logic [31:0]        beacon_sequence,
	input  logic [7:0]         previous_hop,
	input  logic [15:0]        source_x,
	input  logic [15:0]        source_y,
	input  logic [7:0]         hop_count,
	input  logic [31:0]        sent_time,
	input  logic [7:0]         destination,
	output logic [2:0]         status,
	output logic [7:0]         next_hop,
	output logic [7:0]         forward_hop_count,
	output logic [31:0]        send_rate,
	output logic               purge_done
);
	import brar_pkg::*;

	// table storage, one register per entry
	logic [ROUTE_ENTRIES-1:0] valid_q;
	logic [ROUTE_ENTRIES-1:0] expired_q;
	logic [7:0]  dst_q  [ROUTE_ENTRIES];
	logic [31:0] seq_q  [ROUTE_ENTRIES];
	logic [7:0]  nh_q   [ROUTE_ENTRIES];
	logic [31:0] pos_q  [ROUTE_ENTRIES];
	logic [7:0]  hops_q [ROUTE_ENTRIES];
	logic [31:0] exp_q  [ROUTE_ENTRIES];
	logic [31:0] dly_q  [ROUTE_ENTRIES];

	// captured transaction
	action_t     act_q;
	logic [31:0] now_q, seq_in_q, delay_q;
	logic [7:0]  src_q, phop_q, hcnt_q, dest_q;
	logic [31:0] pos_in_q;

	// scan results
	logic [IDX_W-1:0] idx_q;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;

	// rate state
	logic [31:0] rate_q, prev_delay_q;
	logic        first_q;

	// divider
	logic [35:0] rem_q;
	logic [35:0] quo_q;
	logic [5:0]  div_cnt_q;

	logic [7:0]  key;
	logic        match;
	assign key   = (act_q == ACT_LOOKUP) ? dest_q : src_q;
	assign match = valid_q[idx_q] && (dst_q[idx_q] == key);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);
	assign stat.scan_last = (idx_q == LAST_IDX);
	// one quotient bit per step over the 36-bit dividend
	assign stat.div_last  = (div_cnt_q == 6'd36);

	// classification from scan results
	logic is_beacon, own_drop, do_new, do_upd, do_rep;
	assign is_beacon = (act_q == ACT_BEACON);
	assign own_drop  = is_beacon && (src_q == own_address);
	assign do_new    = is_beacon && !own_drop && !hit_q && free_q;
	assign do_upd    = is_beacon && !own_drop && hit_q && (seq_in_q > seq_q[hit_idx_q]);
	assign do_rep    = is_beacon && !own_drop && hit_q && (seq_in_q == seq_q[hit_idx_q])
		&& (delay_q < dly_q[hit_idx_q]);
	assign stat.need_div = is_beacon && (first_q || do_new);

	// AIMD pre-update
	logic [35:0] d10, p11;
	logic [32:0] rsum;
	assign d10  = {4'd0, delay_q} * 36'd10;
	assign p11  = {4'd0, prev_delay_q} * 36'd11;
	assign rsum = {1'b0, rate_q} + {8'd0, rate_step};

	logic [31:0] div_rate;
	assign div_rate = (delay_q == 32'd0 || quo_q[35:32] != 4'd0) ? RATE_MAX : quo_q[31:0];

	logic [35:0] rem_sh;
	logic [36:0] trial;
	assign rem_sh = {rem_q[34:0], quo_q[35]};
	assign trial  = {1'b0, rem_sh} - {5'd0, delay_q};

	logic [7:0] fwd_cnt;
	assign fwd_cnt = (hcnt_q == 8'hFF) ? 8'hFF : hcnt_q + 8'd1;

	logic [IDX_W-1:0] widx;
	assign widx = do_new ? free_idx_q : hit_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rate_q       <= RATE_MAX;
			first_q      <= 1'b1;
			prev_delay_q <= RESET_PREV_DELAY;
			act_q        <= ACT_NONE;
		end else begin
			if (cmd.load) begin
				act_q <= action_t'(action);
			end
			if (cmd.rate_pre && is_beacon) begin
				if (first_q) begin
					prev_delay_q <= RESET_PREV_DELAY;
				end else begin
					rate_q       <= (d10 < p11) ? (rsum[32] ? RATE_MAX : rsum[31:0])
						: {1'b0, rate_q[31:1]};
					prev_delay_q <= delay_q;
				end
			end
			if (cmd.commit) begin
				// first beacon always reloads the rate; a new route again
				if (stat.need_div) begin
					rate_q <= div_rate;
				end
				// first flag held until here so the divide is still requested
				if (is_beacon) begin
					first_q <= 1'b0;
				end
				if (do_new) begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q    <= now;
			seq_in_q <= beacon_sequence;
			delay_q  <= now - sent_time;
			src_q    <= beacon_source;
			phop_q   <= previous_hop;
			hcnt_q   <= hop_count;
			dest_q   <= destination;
			pos_in_q <= {source_x, source_y};
		end
		if (cmd.scan_clr) begin
			idx_q  <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!stat.scan_last) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (!valid_q[idx_q] && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_q;
			end
			if (act_q == ACT_PURGE && valid_q[idx_q] && exp_q[idx_q] <= now_q) begin
				expired_q[idx_q] <= 1'b1;
			end
		end
		if (cmd.div_start) begin
			rem_q     <= '0;
			quo_q     <= ONE_SECOND_Q16;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 6'd1;
			if (!trial[36]) begin
				rem_q <= trial[35:0];
				quo_q <= {quo_q[34:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[34:0], 1'b0};
			end
		end
		if (cmd.commit) begin
			if (do_new) begin
				dst_q[widx] <= src_q;
			end
			if (do_new || do_upd || do_rep) begin
				seq_q[widx]     <= seq_in_q;
				nh_q[widx]      <= phop_q;
				pos_q[widx]     <= pos_in_q;
				hops_q[widx]    <= hcnt_q;
				exp_q[widx]     <= now_q + route_expire_time;
				dly_q[widx]     <= delay_q;
				expired_q[widx] <= 1'b0;
			end
			priority if (act_q == ACT_LOOKUP) begin
				status     <= hit_q ? ST_FOUND : ST_NO_ROUTE;
				next_hop   <= hit_q ? nh_q[hit_idx_q] : 8'd0;
				forward_hop_count <= 8'd0;
			end else if (own_drop) begin
				status <= ST_OWN_DROP;
				next_hop <= 8'd0;
				forward_hop_count <= 8'd0;
			end else if (is_beacon && !hit_q) begin
				status <= free_q ? ST_NEW_FWD : ST_FULL;
				next_hop <= 8'd0;
				forward_hop_count <= free_q ? fwd_cnt : 8'd0;
			end else if (do_upd) begin
				status <= ST_UPD_FWD;
				next_hop <= 8'd0;
				forward_hop_count <= fwd_cnt;
			end else if (do_rep) begin
				status <= ST_REPLACED;
				next_hop <= 8'd0;
				forward_hop_count <= 8'd0;
			end else begin
				status <= ST_IGNORED;
				next_hop <= 8'd0;
				forward_hop_count <= 8'd0;
			end
			purge_done <= (act_q == ACT_PURGE);
		end
	end

	assign send_rate = rate_q;

	// pos_q, hops_q and the expired marks are kept for completeness of the entry
	logic unused_ok;
	assign unused_ok = ^{pos_q[0], hops_q[0], expired_q};

	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && is_beacon) |=> !first_q)
		else $error("first beacon flag not cleared");
	a_no_dup_new: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_new) |-> !valid_q[free_idx_q])
		else $error("insert into used slot");
	a_rate_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !is_beacon) |=> $stable(rate_q))
		else $error("rate changed by non-beacon");

endmodule

>>> design/beacon_route_table_with_aimd_rate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beacon_route_table_with_aimd_rate_core: beacon-fed route table with AIMD rate
// top level: config registers, controller and datapath
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | to core   | in_valid / in_ready   | action .. destination
// out     | from core | out_valid / out_ready | status .. purge_done
// cfg     | to core   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one transaction passes load, the table scan (one table entry per cycle),
// 36 divider steps when the rate needs 1/delay, commit and result, then waits
// for the output; its length is set by the serial table scan and the
// bit-serial 1/delay divider
// arst_n clears the table valid bits, rate and config; no clearing pass
// a stalled result holds the core; the next transaction waits for it
// ----------------------------------------------------------------------------
module beacon_route_table_with_aimd_rate_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] now,
	input  logic [7:0]  beacon_source,
	input  logic [31:0] beacon_sequence,
	input  logic [7:0]  previous_hop,
	input  logic [15:0] source_x,
	input  logic [15:0] source_y,
	input  logic [7:0]  hop_count,
	input  logic [31:0] sent_time,
	input  logic [7:0]  destination,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [7:0]  next_hop,
	output logic [7:0]  forward_hop_count,
	output logic [31:0] send_rate,
	output logic        purge_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import brar_pkg::*;

	// config registers, always writable
	logic [7:0]  own_address_q;
	logic [31:0] expire_q;
	logic [24:0] rate_step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= 8'd0;
			expire_q      <= RESET_EXPIRE;
			rate_step_q   <= RESET_RATE_STEP;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_OWN_ADDRESS: own_address_q <= cfg_data[7:0];
				CFG_EXPIRE_TIME: expire_q      <= cfg_data;
				CFG_RATE_STEP:   rate_step_q   <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;

	brar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	brar_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.own_address       (own_address_q),
		.route_expire_time (expire_q),
		.rate_step         (rate_step_q),
		.action            (action),
		.now               (now),
		.beacon_source     (beacon_source),
		.beacon_sequence   (beacon_sequence),
		.previous_hop      (previous_hop),
		.source_x          (source_x),
		.source_y          (source_y),
		.hop_count         (hop_count),
		.sent_time         (sent_time),
		.destination       (destination),
		.status            (status),
		.next_hop          (next_hop),
		.forward_hop_count (forward_hop_count),
		.send_rate         (send_rate),
		.purge_done        (purge_done)
	);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> in_valid)
		else $error("input valid dropped");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(send_rate)))
		else $error("result changed while stalled");
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port blocked");

endmodule
